// File: rtl/xtte_pkg.sv
// Package for the timestamp-to-epoch unit: shared types, constants and
// small character and calendar helper functions. No dependencies.
package xtte_pkg;

  // Default limit on the trimmed text length.
  localparam int MAX_TEXT_BYTES_DEF = 64;

  // Accumulator widths.
  localparam int ACC_W   = 7;   // two decimal digits, 0..99
  localparam int YY_W    = 14;  // year, 0..9999
  localparam int Q4_W    = 12;  // year / 4, up to 2499
  localparam int DOY_W   = 9;   // day of the March-based year
  localparam int TOD_W   = 19;  // seconds of day or zone offset, unchecked fields
  localparam int DELTA_W = 21;  // signed time of day minus offset
  localparam int DAYS_W  = 24;  // signed days since 1970-01-01
  localparam int RAW_W   = 23;  // unsigned day count before the epoch shift
  localparam int PTOD_W  = 31;  // signed delta in milliseconds
  localparam int MS_W    = 49;  // signed result in milliseconds

  localparam int DIGITS_LAST = 13;  // index of the last date/time digit

  localparam logic [6:0] MONTH_FEB = 7'd2;
  localparam logic [6:0] MAX_HOUR  = 7'd23;
  localparam logic [6:0] MAX_MIN   = 7'd59;
  localparam logic [6:0] MAX_SEC   = 7'd59;
  localparam logic [6:0] MAX_DD    = 7'd99;

  localparam logic [YY_W-1:0]    YEAR_SCALE    = 14'd100;
  localparam logic [Q4_W-1:0]    YEAR_QUARTER  = 12'd25;
  localparam logic [RAW_W-1:0]   DAYS_PER_YEAR = 23'd365;
  localparam logic [TOD_W-1:0]   SEC_PER_HOUR  = 19'd3600;
  localparam logic [TOD_W-1:0]   SEC_PER_MIN   = 19'd60;
  localparam logic signed [DAYS_W-1:0] EPOCH_DAY_OFFSET = 24'sd719468;
  localparam logic signed [27:0] MS_PER_DAY    = 28'sd86400000;
  localparam logic signed [10:0] MS_PER_SEC    = 11'sd1000;

  // Characters with a special meaning to the scanner.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_Z_UP  = 8'h5A;
  localparam logic [7:0] CH_Z_LO  = 8'h7A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  // Commands from the controller.
  typedef struct packed {
    logic take;     // scanner consumes the current byte
    logic clear;    // scanner returns to its reset state
    logic ld_chk;   // validate fields and split the year
    logic ld_days;  // form the day count and the signed time of day
    logic ld_mul;   // scale both to milliseconds
    logic ld_out;   // load the output register
  } cmd_t;

  // Fields collected by the scanner.
  typedef struct packed {
    logic             complete;  // all fourteen digits seen, zone well formed so far
    logic             failed;
    logic [ACC_W-1:0] year_hi;   // first two year digits
    logic [ACC_W-1:0] year_lo;   // last two year digits
    logic [ACC_W-1:0] month;
    logic [ACC_W-1:0] day;
    logic [ACC_W-1:0] hour;
    logic [ACC_W-1:0] minute;
    logic [ACC_W-1:0] second;
    logic             zone_neg;
    logic [ACC_W-1:0] zone_hour;
    logic [ACC_W-1:0] zone_min;
  } scan_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // One more decimal digit into a two-digit accumulator.
  function automatic logic [ACC_W-1:0] acc10(input logic [ACC_W-1:0] acc,
                                             input logic [3:0] dv);
    return ACC_W'(acc * 7'd10 + ACC_W'(dv));
  endfunction

  // Length of a month; zero for a month number that does not exist.
  function automatic logic [4:0] month_len(input logic [ACC_W-1:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
      7'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // Days from March 1 to the first of the month, in a March-based year.
  function automatic logic [DOY_W-1:0] doy_base(input logic [ACC_W-1:0] m);
    logic [DOY_W-1:0] b;
    case (m)
      7'd3:    b = 9'd0;
      7'd4:    b = 9'd31;
      7'd5:    b = 9'd61;
      7'd6:    b = 9'd92;
      7'd7:    b = 9'd122;
      7'd8:    b = 9'd153;
      7'd9:    b = 9'd184;
      7'd10:   b = 9'd214;
      7'd11:   b = 9'd245;
      7'd12:   b = 9'd275;
      7'd1:    b = 9'd306;
      7'd2:    b = 9'd337;
      default: b = 9'd0;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/xtte_scan.sv
// Byte scanner: trims whitespace, counts length and collects the date,
// time and zone digits. Depends on xtte_pkg.
module xtte_scan #(
  parameter int MAX_TEXT_BYTES = xtte_pkg::MAX_TEXT_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  xtte_pkg::cmd_t      cmd_i,
  input  logic [7:0]          char_byte_i,
  output xtte_pkg::scan_t     scan_o
);

  // Length counters hold up to MAX_TEXT_BYTES + 1, which already means too long.
  localparam int CW = $clog2(MAX_TEXT_BYTES + 2);
  localparam logic [CW-1:0] LEN_SAT = CW'(MAX_TEXT_BYTES + 1);
  localparam logic [CW:0]   LEN_MAX = (CW + 1)'(MAX_TEXT_BYTES);

  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_DIGITS = 3'd1;
  localparam logic [2:0] PH_GAP    = 3'd2;
  localparam logic [2:0] PH_ZONE   = 3'd3;
  localparam logic [2:0] PH_TAIL   = 3'd4;

  localparam int AW = xtte_pkg::ACC_W;

  logic [2:0]    phase_q, phase_d;
  logic [3:0]    dcnt_q, dcnt_d;
  logic [1:0]    zcnt_q, zcnt_d;
  logic [AW-1:0] yhi_q, yhi_d, ylo_q, ylo_d, mon_q, mon_d, day_q, day_d;
  logic [AW-1:0] hr_q, hr_d, min_q, min_d, sec_q, sec_d;
  logic [AW-1:0] zhr_q, zhr_d, zmin_q, zmin_d;
  logic          zneg_q, zneg_d;
  logic [CW-1:0] content_q, content_d, pend_q, pend_d;
  logic          failed_q, failed_d;

  always_comb begin
    logic       ws;
    logic       dig;
    logic [3:0] dv;
    logic [2:0] ph;
    logic       fail;
    logic [CW:0] sum;

    ws   = xtte_pkg::is_ws(char_byte_i);
    dig  = xtte_pkg::is_digit(char_byte_i);
    dv   = char_byte_i[3:0];
    ph   = phase_q;
    fail = failed_q;
    sum  = (CW + 1)'(content_q) + (CW + 1)'(pend_q) + (CW + 1)'(1);

    phase_d   = phase_q;
    dcnt_d    = dcnt_q;
    zcnt_d    = zcnt_q;
    yhi_d     = yhi_q;
    ylo_d     = ylo_q;
    mon_d     = mon_q;
    day_d     = day_q;
    hr_d      = hr_q;
    min_d     = min_q;
    sec_d     = sec_q;
    zhr_d     = zhr_q;
    zmin_d    = zmin_q;
    zneg_d    = zneg_q;
    content_d = content_q;
    pend_d    = pend_q;
    failed_d  = failed_q;

    if (cmd_i.clear) begin
      phase_d   = PH_LEAD;
      dcnt_d    = '0;
      zcnt_d    = '0;
      yhi_d     = '0;
      ylo_d     = '0;
      mon_d     = '0;
      day_d     = '0;
      hr_d      = '0;
      min_d     = '0;
      sec_d     = '0;
      zhr_d     = '0;
      zmin_d    = '0;
      zneg_d    = 1'b0;
      content_d = '0;
      pend_d    = '0;
      failed_d  = 1'b0;
    end else if (cmd_i.take && !(phase_q == PH_LEAD && ws)) begin
      if (phase_q == PH_LEAD) begin
        ph = PH_DIGITS;
      end
      phase_d = ph;

      // Whitespace only counts once more text follows it.
      if (ws) begin
        if (pend_q != LEN_SAT) begin
          pend_d = pend_q + CW'(1);
        end
      end else begin
        if (sum > LEN_MAX) begin
          fail = 1'b1;
        end
        content_d = (sum > (CW + 1)'(LEN_SAT)) ? LEN_SAT : sum[CW-1:0];
        pend_d    = '0;
      end

      if (!fail) begin
        if (char_byte_i == xtte_pkg::CH_NUL) begin
          fail = 1'b1;
        end else begin
          case (ph)
            PH_DIGITS: begin
              if (!dig) begin
                fail = 1'b1;
              end else begin
                case (dcnt_q)
                  4'd0, 4'd1:   yhi_d = xtte_pkg::acc10(yhi_q, dv);
                  4'd2, 4'd3:   ylo_d = xtte_pkg::acc10(ylo_q, dv);
                  4'd4, 4'd5:   mon_d = xtte_pkg::acc10(mon_q, dv);
                  4'd6, 4'd7:   day_d = xtte_pkg::acc10(day_q, dv);
                  4'd8, 4'd9:   hr_d  = xtte_pkg::acc10(hr_q, dv);
                  4'd10, 4'd11: min_d = xtte_pkg::acc10(min_q, dv);
                  default:      sec_d = xtte_pkg::acc10(sec_q, dv);
                endcase
                dcnt_d = dcnt_q + 4'd1;
                if (dcnt_q == 4'(xtte_pkg::DIGITS_LAST)) begin
                  phase_d = PH_GAP;
                end
              end
            end
            PH_GAP: begin
              if (!ws) begin
                if (char_byte_i == xtte_pkg::CH_Z_UP || char_byte_i == xtte_pkg::CH_Z_LO) begin
                  phase_d = PH_TAIL;
                end else if (char_byte_i == xtte_pkg::CH_PLUS ||
                             char_byte_i == xtte_pkg::CH_MINUS) begin
                  zneg_d  = (char_byte_i == xtte_pkg::CH_MINUS);
                  phase_d = PH_ZONE;
                end else begin
                  fail = 1'b1;
                end
              end
            end
            PH_ZONE: begin
              if (!dig) begin
                fail = 1'b1;
              end else begin
                if (!zcnt_q[1]) begin
                  zhr_d = xtte_pkg::acc10(zhr_q, dv);
                end else begin
                  zmin_d = xtte_pkg::acc10(zmin_q, dv);
                end
                zcnt_d = zcnt_q + 2'd1;
                if (zcnt_q == 2'd3) begin
                  phase_d = PH_TAIL;
                end
              end
            end
            PH_TAIL: begin
              if (!ws) begin
                fail = 1'b1;
              end
            end
            default: fail = 1'b1;
          endcase
        end
      end
      failed_d = fail;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LEAD;
      dcnt_q    <= '0;
      zcnt_q    <= '0;
      yhi_q     <= '0;
      ylo_q     <= '0;
      mon_q     <= '0;
      day_q     <= '0;
      hr_q      <= '0;
      min_q     <= '0;
      sec_q     <= '0;
      zhr_q     <= '0;
      zmin_q    <= '0;
      zneg_q    <= 1'b0;
      content_q <= '0;
      pend_q    <= '0;
      failed_q  <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      dcnt_q    <= dcnt_d;
      zcnt_q    <= zcnt_d;
      yhi_q     <= yhi_d;
      ylo_q     <= ylo_d;
      mon_q     <= mon_d;
      day_q     <= day_d;
      hr_q      <= hr_d;
      min_q     <= min_d;
      sec_q     <= sec_d;
      zhr_q     <= zhr_d;
      zmin_q    <= zmin_d;
      zneg_q    <= zneg_d;
      content_q <= content_d;
      pend_q    <= pend_d;
      failed_q  <= failed_d;
    end
  end

  assign scan_o.complete  = (phase_q == PH_GAP) || (phase_q == PH_TAIL);
  assign scan_o.failed    = failed_q;
  assign scan_o.year_hi   = yhi_q;
  assign scan_o.year_lo   = ylo_q;
  assign scan_o.month     = mon_q;
  assign scan_o.day       = day_q;
  assign scan_o.hour      = hr_q;
  assign scan_o.minute    = min_q;
  assign scan_o.second    = sec_q;
  assign scan_o.zone_neg  = zneg_q;
  assign scan_o.zone_hour = zhr_q;
  assign scan_o.zone_min  = zmin_q;

endmodule

// File: rtl/xtte_calc.sv
// Arithmetic datapath: validates the collected fields, forms the day count
// and scales everything to milliseconds over four steps. Depends on xtte_pkg.
module xtte_calc (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  xtte_pkg::cmd_t                         cmd_i,
  input  xtte_pkg::scan_t                        scan_i,
  output logic                                   ok_o,
  output logic signed [xtte_pkg::MS_W-1:0]       epoch_ms_o
);

  localparam int AW = xtte_pkg::ACC_W;

  // Step one: validation, year taken back by one for January and February.
  logic                        ok_q, ok_d;
  logic [xtte_pkg::YY_W-1:0]   yy_q, yy_d;
  logic [xtte_pkg::Q4_W-1:0]   q4_q, q4_d;
  logic [AW-1:0]               cent_q, cent_d;
  logic [xtte_pkg::DOY_W-1:0]  doy_q, doy_d;
  logic [xtte_pkg::TOD_W-1:0]  tod_q, tod_d, off_q, off_d;
  logic                        zneg_q;
  // Step two.
  logic signed [xtte_pkg::DAYS_W-1:0]  days_q, days_d;
  logic signed [xtte_pkg::DELTA_W-1:0] delta_q, delta_d;
  // Step three.
  logic signed [xtte_pkg::MS_W-1:0]    pday_q, pday_d;
  logic signed [xtte_pkg::PTOD_W-1:0]  ptod_q, ptod_d;
  // Output register.
  logic                                ok_out_q;
  logic signed [xtte_pkg::MS_W-1:0]    ms_out_q, ms_out_d;

  always_comb begin
    logic          leap;
    logic [4:0]    mlen;
    logic [AW-1:0] hi_adj;
    logic [AW-1:0] lo_adj;

    // The year has exactly four digits, so its two halves settle the leap rule.
    leap = (scan_i.year_lo == '0) ? (scan_i.year_hi[1:0] == 2'b00)
                                  : (scan_i.year_lo[1:0] == 2'b00);
    mlen = xtte_pkg::month_len(scan_i.month, leap);

    ok_d = !scan_i.failed && scan_i.complete &&
           !(scan_i.year_hi == '0 && scan_i.year_lo == '0) &&
           (scan_i.day != '0) && (scan_i.day <= AW'(mlen)) &&
           (scan_i.hour <= xtte_pkg::MAX_HOUR) &&
           (scan_i.minute <= xtte_pkg::MAX_MIN) &&
           (scan_i.second <= xtte_pkg::MAX_SEC);

    // Count years from March so that the leap day ends the year.
    hi_adj = scan_i.year_hi;
    lo_adj = scan_i.year_lo;
    if (scan_i.month <= xtte_pkg::MONTH_FEB) begin
      if (scan_i.year_lo == '0) begin
        hi_adj = scan_i.year_hi - AW'(1);
        lo_adj = xtte_pkg::MAX_DD;
      end else begin
        lo_adj = scan_i.year_lo - AW'(1);
      end
    end

    yy_d   = xtte_pkg::YY_W'(hi_adj * xtte_pkg::YEAR_SCALE + xtte_pkg::YY_W'(lo_adj));
    q4_d   = xtte_pkg::Q4_W'(xtte_pkg::Q4_W'(hi_adj) * xtte_pkg::YEAR_QUARTER +
                             xtte_pkg::Q4_W'(lo_adj >> 2));
    cent_d = hi_adj;
    doy_d  = xtte_pkg::doy_base(scan_i.month) + xtte_pkg::DOY_W'(scan_i.day) -
             xtte_pkg::DOY_W'(1);
    tod_d  = xtte_pkg::TOD_W'(xtte_pkg::TOD_W'(scan_i.hour) * xtte_pkg::SEC_PER_HOUR +
                              xtte_pkg::TOD_W'(scan_i.minute) * xtte_pkg::SEC_PER_MIN +
                              xtte_pkg::TOD_W'(scan_i.second));
    off_d  = xtte_pkg::TOD_W'(xtte_pkg::TOD_W'(scan_i.zone_hour) * xtte_pkg::SEC_PER_HOUR +
                              xtte_pkg::TOD_W'(scan_i.zone_min) * xtte_pkg::SEC_PER_MIN);
  end

  always_comb begin
    logic [xtte_pkg::RAW_W-1:0]         raw;
    logic signed [xtte_pkg::DELTA_W-1:0] tod_s;
    logic signed [xtte_pkg::DELTA_W-1:0] off_s;

    // 365 y + y/4 - y/100 + y/400 + day of year, all in whole days.
    raw = xtte_pkg::RAW_W'(yy_q * xtte_pkg::DAYS_PER_YEAR) + xtte_pkg::RAW_W'(q4_q) -
          xtte_pkg::RAW_W'(cent_q) + xtte_pkg::RAW_W'(cent_q >> 2) +
          xtte_pkg::RAW_W'(doy_q);
    days_d = $signed({1'b0, raw}) - xtte_pkg::EPOCH_DAY_OFFSET;

    tod_s   = $signed({2'b00, tod_q});
    off_s   = $signed({2'b00, off_q});
    delta_d = zneg_q ? (tod_s + off_s) : (tod_s - off_s);

    pday_d = xtte_pkg::MS_W'(days_q) * xtte_pkg::MS_W'(xtte_pkg::MS_PER_DAY);
    ptod_d = xtte_pkg::PTOD_W'(delta_q) * xtte_pkg::PTOD_W'(xtte_pkg::MS_PER_SEC);

    ms_out_d = ok_q ? (pday_q + xtte_pkg::MS_W'(ptod_q)) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_chk) begin
      yy_q   <= yy_d;
      q4_q   <= q4_d;
      cent_q <= cent_d;
      doy_q  <= doy_d;
      tod_q  <= tod_d;
      off_q  <= off_d;
      zneg_q <= scan_i.zone_neg;
    end
    if (cmd_i.ld_days) begin
      days_q  <= days_d;
      delta_q <= delta_d;
    end
    if (cmd_i.ld_mul) begin
      pday_q <= pday_d;
      ptod_q <= ptod_d;
    end
    if (cmd_i.ld_out) begin
      ms_out_q <= ms_out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q     <= 1'b0;
      ok_out_q <= 1'b0;
    end else begin
      if (cmd_i.ld_chk) begin
        ok_q <= ok_d;
      end
      if (cmd_i.ld_out) begin
        ok_out_q <= ok_q;
      end
    end
  end

  assign ok_o       = ok_out_q;
  assign epoch_ms_o = ms_out_q;

endmodule

// File: rtl/xtte_ctrl.sv
// Controller: handshakes on both channels and sequences the conversion
// steps once a string ends. Depends on xtte_pkg.
module xtte_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           byte_valid_i,
  input  logic           last_i,
  input  logic           out_stall_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  output xtte_pkg::cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CHK  = 3'd1;
  localparam logic [2:0] ST_DAYS = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.take = accept && byte_valid_i;
        if (accept && last_i) begin
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        cmd_o.ld_chk = 1'b1;
        cmd_o.clear  = 1'b1;
        state_d      = ST_DAYS;
      end
      ST_DAYS: begin
        cmd_o.ld_days = 1'b1;
        state_d       = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.ld_mul = 1'b1;
        state_d      = ST_DONE;
      end
      ST_DONE: begin
        // Wait here while an earlier result is still held at the output.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.ld_out = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.ld_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/xmltv_timestamp_to_epoch_ms_unit.sv
// Timestamp text to UTC epoch milliseconds. Input bytes are taken at one per cycle while
// the unit is idle; the transaction that ends a string starts four conversion steps
// (check, day count, multiply, sum), and the input stalls through those steps, longer
// while an earlier result is still held at the output.
// Reset (asynchronous, active low) empties the scanner and drops any pending result.
module xmltv_timestamp_to_epoch_ms_unit #(
  parameter int MAX_TEXT_BYTES = xtte_pkg::MAX_TEXT_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input channel: one byte of timestamp text per transaction.
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        char_byte_i,
  input  logic                              byte_valid_i,
  input  logic                              last_i,
  // Output channel: one result per string.
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              ok_o,
  output logic signed [xtte_pkg::MS_W-1:0]  epoch_ms_o
);

  xtte_pkg::cmd_t  cmd;
  xtte_pkg::scan_t scan;

  // The controller owns both handshakes. While idle it passes every byte that
  // carries data to the scanner; a transaction with last set then walks the
  // arithmetic through its four steps and loads the output register as soon
  // as the previous result has been taken.
  xtte_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .byte_valid_i (byte_valid_i),
    .last_i       (last_i),
    .out_stall_i  (out_stall_i),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .cmd_o        (cmd)
  );

  // The scanner does all per-byte work in the cycle the byte is accepted:
  // whitespace trimming, the length limit, and digit accumulation. It is
  // cleared in the first conversion step, after its fields have been sampled.
  xtte_scan #(
    .MAX_TEXT_BYTES (MAX_TEXT_BYTES)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .char_byte_i (char_byte_i),
    .scan_o      (scan)
  );

  // The arithmetic keeps one multiplication between registers: the day count
  // and the time of day are formed first, then each is scaled to milliseconds
  // by its own constant multiplier, and a final add forms the result.
  xtte_calc u_calc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .scan_i     (scan),
    .ok_o       (ok_o),
    .epoch_ms_o (epoch_ms_o)
  );

endmodule
